FILE: rtl/daq_pkg.sv
`default_nettype none
package daq_pkg;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_OUTBOUND = 2'd1;
  localparam logic [1:0] CMD_RETURN = 2'd2;

  localparam logic MODE_DEADLINE = 1'b0;
  localparam logic MODE_CONTEND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MASK,
    ST_PLACE,
    ST_DONE
  } daq_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic write_head;
    logic pop;
    logic sel_frame;
    logic sel_req;
    logic calc_mask;
    logic place;
    logic set_contend;
    logic clr_contend;
    logic win;
    logic drop;
    logic load_out;
  } daq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] command;
    logic       mode;
    logic       empty;
    logic       full;
    logic       contending;
    logic       dl_take;
    logic       code_take;
    logic       stamp_match;
    logic       head_match;
    logic       fd_zero;
  } daq_status_t;

endpackage
`default_nettype wire

FILE: rtl/daq_ctrl.sv
`default_nettype none
module daq_ctrl
  import daq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire daq_status_t st,
  output daq_cmd_t         cmd
);

  daq_state_t state, state_next;
  logic out_free;
  logic out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (state == ST_DONE && out_free) begin
      out_valid_next = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_DONE;
        case (st.command)
          CMD_ENQUEUE: begin
            if (!st.full) begin
              state_next = ST_MASK;
            end
          end
          CMD_OUTBOUND: begin
            if (!st.contending && !st.empty && st.mode == MODE_DEADLINE &&
                st.dl_take && !st.fd_zero) begin
              state_next = ST_MASK;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_MASK: state_next = ST_PLACE;
      ST_PLACE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.load_in = in_valid;
      ST_EVAL: begin
        case (st.command)
          CMD_ENQUEUE: begin
            cmd.drop = st.full;
            cmd.sel_req = !st.full;
          end
          CMD_OUTBOUND: begin
            if (!st.contending && !st.empty) begin
              if (st.mode == MODE_DEADLINE) begin
                cmd.write_head = st.dl_take;
                cmd.pop = st.dl_take;
                cmd.sel_frame = st.dl_take && !st.fd_zero;
              end else begin
                cmd.write_head = st.code_take;
                cmd.set_contend = st.code_take;
              end
            end
          end
          CMD_RETURN: begin
            if (st.mode == MODE_CONTEND && st.contending && !st.empty &&
                st.stamp_match) begin
              cmd.clr_contend = 1'b1;
              cmd.pop = st.head_match;
              cmd.win = st.head_match;
            end
          end
          default: cmd = '0;
        endcase
      end
      ST_MASK: cmd.calc_mask = 1'b1;
      ST_PLACE: cmd.place = 1'b1;
      ST_DONE: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/daq_datapath.sv
`default_nettype none
module daq_datapath
  import daq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH = 32,
  parameter int CLASS_BITS = 8,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_data,
  input  wire logic [1:0]            command,
  input  wire logic [15:0]           req_code,
  input  wire logic [TIME_WIDTH-1:0] req_deadline,
  input  wire logic [15:0]           frame_code,
  input  wire logic [TIME_WIDTH-1:0] frame_deadline,
  input  wire logic [TIME_WIDTH-1:0] frame_stamp,
  input  wire daq_cmd_t              cmd,
  output daq_status_t                st,
  output logic                       frame_written,
  output logic [15:0]                out_code,
  output logic [TIME_WIDTH-1:0]      out_deadline,
  output logic                       won,
  output logic [CW-1:0]              entries_held,
  output logic                       insert_dropped
);

  logic [15:0]           q_code [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0] q_dl [QUEUE_DEPTH];
  logic [CW-1:0]         count;
  logic                  mode;
  logic                  contending;
  logic [TIME_WIDTH-1:0] saved_stamp;
  logic [31:0]           win_total;

  logic [1:0]            l_cmd;
  logic [15:0]           l_req_code, l_fc;
  logic [TIME_WIDTH-1:0] l_req_dl, l_fd, l_fs;

  logic [15:0]           ins_code;
  logic [TIME_WIDTH-1:0] ins_dl;
  logic [QUEUE_DEPTH-1:0] gt_mask;

  logic                  res_written, res_won, res_dropped;
  logic [15:0]           res_code;
  logic [TIME_WIDTH-1:0] res_dl;

  logic [TIME_WIDTH-1:0] ins_key;
  logic [QUEUE_DEPTH-1:0] gt_calc;
  logic [QUEUE_DEPTH-1:0] pre;

  function automatic logic [TIME_WIDTH-1:0] key_of(
    input logic m, input logic [15:0] c, input logic [TIME_WIDTH-1:0] d);
    logic [TIME_WIDTH-1:0] k;
    k = d;
    if (m == MODE_CONTEND) begin
      k = TIME_WIDTH'(c[15 -: CLASS_BITS]);
    end
    return k;
  endfunction

  assign ins_key = key_of(mode, ins_code, ins_dl);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt_calc[i] = (CW'(i) < count) && (key_of(mode, q_code[i], q_dl[i]) > ins_key);
    end
  end

  // Inclusive prefix OR of the greater mask marks entries at or past the slot.
  always_comb begin
    pre[0] = gt_mask[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      pre[i] = pre[i-1] | gt_mask[i];
    end
  end

  assign st.command     = l_cmd;
  assign st.mode        = mode;
  assign st.empty       = (count == '0);
  assign st.full        = (count >= CW'(QUEUE_DEPTH));
  assign st.contending  = contending;
  assign st.dl_take     = (l_fd == '0) || (l_fd > q_dl[0]);
  assign st.code_take   = (l_fc > q_code[0]);
  assign st.stamp_match = (saved_stamp == l_fs);
  assign st.head_match  = (q_code[0] == l_fc) && (q_dl[0] == l_fd);
  assign st.fd_zero     = (l_fd == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mode <= MODE_DEADLINE;
      contending <= 1'b0;
      saved_stamp <= '0;
      win_total <= '0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_data;
      end
      if (cmd.pop) begin
        count <= count - 1'b1;
      end else if (cmd.place) begin
        count <= count + 1'b1;
      end
      if (cmd.set_contend) begin
        contending <= 1'b1;
        saved_stamp <= l_fs;
      end else if (cmd.clr_contend) begin
        contending <= 1'b0;
      end
      if (cmd.win) begin
        win_total <= win_total + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        q_code[i] <= q_code[i+1];
        q_dl[i] <= q_dl[i+1];
      end
    end else if (cmd.place) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i == 0) begin
          if (gt_mask[0] || (!pre[QUEUE_DEPTH-1] && count == '0)) begin
            q_code[0] <= ins_code;
            q_dl[0] <= ins_dl;
          end
        end else if (pre[i-1]) begin
          q_code[i] <= q_code[i-1];
          q_dl[i] <= q_dl[i-1];
        end else if (gt_mask[i] || (!pre[QUEUE_DEPTH-1] && count == CW'(i))) begin
          q_code[i] <= ins_code;
          q_dl[i] <= ins_dl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      l_cmd <= command;
      l_req_code <= req_code;
      l_req_dl <= req_deadline;
      l_fc <= frame_code;
      l_fd <= frame_deadline;
      l_fs <= frame_stamp;
      res_code <= frame_code;
      res_dl <= frame_deadline;
      res_written <= 1'b0;
      res_won <= 1'b0;
      res_dropped <= 1'b0;
    end
    if (cmd.write_head) begin
      res_code <= q_code[0];
      res_dl <= q_dl[0];
      res_written <= 1'b1;
    end
    if (cmd.win) begin
      res_won <= 1'b1;
    end
    if (cmd.drop) begin
      res_dropped <= 1'b1;
    end
    if (cmd.sel_req) begin
      ins_code <= l_req_code;
      ins_dl <= l_req_dl;
    end else if (cmd.sel_frame) begin
      ins_code <= l_fc;
      ins_dl <= l_fd;
    end
    if (cmd.calc_mask) begin
      gt_mask <= gt_calc;
    end
    if (cmd.load_out) begin
      frame_written <= res_written;
      out_code <= res_code;
      out_deadline <= res_dl;
      won <= res_won;
      entries_held <= count;
      insert_dropped <= res_dropped;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/deadline_arbitration_queue.sv
// Sequence: after an input transfer, EVAL then DONE, which loads the result,
// for return commands, dropped enqueues and frames that insert nothing; an
// insert puts MASK (mask compare) and PLACE (shift place) before DONE.
// The single-item sequencer takes no new item before its result is loaded;
// a stalled result holds the sequencer and the input until it transfers.
// Reset (rst, synchronous, active high) empties the queue, clears contention,
// the saved stamp and the win count, and selects deadline mode.
`default_nettype none
module deadline_arbitration_queue
  import daq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH = 32,
  parameter int CLASS_BITS = 8,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            command,
  input  wire logic [15:0]           req_code,
  input  wire logic [TIME_WIDTH-1:0] req_deadline,
  input  wire logic [15:0]           frame_code,
  input  wire logic [TIME_WIDTH-1:0] frame_deadline,
  input  wire logic [TIME_WIDTH-1:0] frame_stamp,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       frame_written,
  output logic [15:0]                out_code,
  output logic [TIME_WIDTH-1:0]      out_deadline,
  output logic                       won,
  output logic [CW-1:0]              entries_held,
  output logic                       insert_dropped
);

  // Command and status bundles between the sequencer and the queue datapath.
  daq_cmd_t    cmd;
  daq_status_t st;

  // Sequencer: capture one item, evaluate the head, pop and insert as needed,
  // then transfer the result through the output register.
  daq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: sorted shift queue, input latch, contention state and results.
  daq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .CLASS_BITS  (CLASS_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .command        (command),
    .req_code       (req_code),
    .req_deadline   (req_deadline),
    .frame_code     (frame_code),
    .frame_deadline (frame_deadline),
    .frame_stamp    (frame_stamp),
    .cmd            (cmd),
    .st             (st),
    .frame_written  (frame_written),
    .out_code       (out_code),
    .out_deadline   (out_deadline),
    .won            (won),
    .entries_held   (entries_held),
    .insert_dropped (insert_dropped)
  );

endmodule
`default_nettype wire

FILE: rtl/daq_checker.sv
`default_nettype none
module daq_checker #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire logic          frame_written,
  input wire logic          won,
  input wire logic          insert_dropped,
  input wire logic [CW-1:0] entries_held
);

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entries_held <= CW'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({frame_written, won, insert_dropped}) <= 1)
    else $error("conflicting result flags");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && insert_dropped) |-> entries_held == CW'(QUEUE_DEPTH))
    else $error("drop while not full");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(entries_held))
    else $error("stalled result changed");

endmodule

bind deadline_arbitration_queue daq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_daq_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .frame_written  (frame_written),
  .won            (won),
  .insert_dropped (insert_dropped),
  .entries_held   (entries_held)
);
`default_nettype wire
